/* src/lcdns_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and bit-update functions for the LCD nibble frame sequencer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package lcdns_pkg;

  // Input item kind codes.
  localparam logic [2:0] KIND_CMD     = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_INIT    = 3'd2;
  localparam logic [2:0] KIND_BL_ON   = 3'd3;
  localparam logic [2:0] KIND_BL_OFF  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_RS = 3'd0;
  localparam logic [2:0] REG_EN = 3'd1;
  localparam logic [2:0] REG_BL = 3'd2;
  localparam logic [2:0] REG_D4 = 3'd3;
  localparam logic [2:0] REG_D5 = 3'd4;
  localparam logic [2:0] REG_D6 = 3'd5;
  localparam logic [2:0] REG_D7 = 3'd6;

  // Last step of each sequence.
  localparam logic [3:0] BYTE_LAST_STEP   = 4'd8;
  localparam logic [3:0] NIBBLE_LAST_STEP = 4'd3;

  // Nibble sub-steps.
  localparam logic [1:0] SUB_DATA   = 2'd0;
  localparam logic [1:0] SUB_EN_LO1 = 2'd1;
  localparam logic [1:0] SUB_EN_HI  = 2'd2;
  localparam logic [1:0] SUB_EN_LO2 = 2'd3;

  typedef enum logic [2:0] {
    OP_CMD,
    OP_DATA,
    OP_INIT,
    OP_BL_ON,
    OP_BL_OFF
  } op_t;

  // One classified item waiting in the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } entry_t;

  // Line positions within the shift register.
  typedef struct packed {
    logic [2:0] rs;
    logic [2:0] en;
    logic [2:0] bl;
    logic [2:0] d4;
    logic [2:0] d5;
    logic [2:0] d6;
    logic [2:0] d7;
  } cfg_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] put_bit(input logic [7:0] b, input logic [2:0] pos,
                                         input logic v);
    logic [7:0] r;
    r      = b;
    r[pos] = v;
    return r;
  endfunction

  // One frame step of a nibble transfer: data lines, then enable low, high, low.
  function automatic logic [7:0] nibble_step(input logic [7:0] b, input cfg_t c,
                                             input logic [1:0] sub, input logic [3:0] nib);
    logic [7:0] r;
    r = b;
    case (sub)
      SUB_DATA: begin
        r = put_bit(r, c.d4, nib[0]);
        r = put_bit(r, c.d5, nib[1]);
        r = put_bit(r, c.d6, nib[2]);
        r = put_bit(r, c.d7, nib[3]);
      end
      SUB_EN_HI:  r = put_bit(r, c.en, 1'b1);
      SUB_EN_LO1: r = put_bit(r, c.en, 1'b0);
      SUB_EN_LO2: r = put_bit(r, c.en, 1'b0);
      default:    r = b;
    endcase
    return r;
  endfunction

endpackage

/* src/lcdns_front.sv */
`timescale 1ns / 1ps
// Front part: accepts input items, classifies the kind and pushes work to the queue.
// Depends on lcdns_pkg.
module lcdns_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           kind,
  input  logic [7:0]           payload,
  input  lcdns_pkg::q_status_t q_status,
  output logic                 push,
  output lcdns_pkg::entry_t    push_entry
);

  logic known;

  // Decode the kind; unused kinds are taken and dropped.
  always_comb begin
    known            = 1'b1;
    push_entry.data  = payload;
    push_entry.op    = lcdns_pkg::OP_CMD;
    case (kind)
      lcdns_pkg::KIND_CMD:    push_entry.op = lcdns_pkg::OP_CMD;
      lcdns_pkg::KIND_DATA:   push_entry.op = lcdns_pkg::OP_DATA;
      lcdns_pkg::KIND_INIT:   push_entry.op = lcdns_pkg::OP_INIT;
      lcdns_pkg::KIND_BL_ON:  push_entry.op = lcdns_pkg::OP_BL_ON;
      lcdns_pkg::KIND_BL_OFF: push_entry.op = lcdns_pkg::OP_BL_OFF;
      default:                known = 1'b0;
    endcase
  end

  // An item is held off only while the queue is full.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full && known;

endmodule

/* src/lcdns_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified items between the front and back parts.
// Depends on lcdns_pkg.
module lcdns_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lcdns_pkg::entry_t    push_entry,
  input  logic                 pop,
  output lcdns_pkg::entry_t    head,
  output lcdns_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lcdns_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

endmodule

/* src/lcdns_back.sv */
`timescale 1ns / 1ps
// Back part: steps through the head item's frames, one per cycle unless stalled,
// keeping the shadow byte and a registered output. Depends on lcdns_pkg.
module lcdns_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lcdns_pkg::cfg_t      cfg,
  input  lcdns_pkg::entry_t    head,
  input  lcdns_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           frame,
  output logic                 last
);

  logic [7:0] shadow;
  logic [7:0] shadow_next;
  logic [3:0] step;
  logic [3:0] rel;
  logic [1:0] sub;
  logic [3:0] nib;
  logic       do_nib;
  logic       is_last;
  logic       advance;

  // Next shadow value for the current step of the head item.
  always_comb begin
    shadow_next = shadow;
    rel         = 4'd0;
    sub         = lcdns_pkg::SUB_DATA;
    nib         = 4'd0;
    do_nib      = 1'b0;
    is_last     = 1'b0;
    case (head.op)
      lcdns_pkg::OP_CMD, lcdns_pkg::OP_DATA: begin
        is_last = (step == lcdns_pkg::BYTE_LAST_STEP);
        if (step == 4'd0) begin
          shadow_next = lcdns_pkg::put_bit(shadow, cfg.rs, head.op == lcdns_pkg::OP_DATA);
        end else if (step <= 4'd4) begin
          rel    = step - 4'd1;
          nib    = head.data[7:4];
          do_nib = 1'b1;
        end else begin
          rel    = step - 4'd5;
          nib    = head.data[3:0];
          do_nib = 1'b1;
        end
      end
      lcdns_pkg::OP_INIT: begin
        is_last = (step == lcdns_pkg::NIBBLE_LAST_STEP);
        rel     = step;
        nib     = head.data[3:0];
        do_nib  = 1'b1;
      end
      lcdns_pkg::OP_BL_ON: begin
        is_last     = 1'b1;
        shadow_next = lcdns_pkg::put_bit(shadow, cfg.bl, 1'b0);
      end
      lcdns_pkg::OP_BL_OFF: begin
        is_last     = 1'b1;
        shadow_next = lcdns_pkg::put_bit(shadow, cfg.bl, 1'b1);
      end
      default: is_last = 1'b1;
    endcase
    sub = rel[1:0];
    if (do_nib) begin
      shadow_next = lcdns_pkg::nibble_step(shadow, cfg, sub, nib);
    end
  end

  // A frame is made whenever work waits and the output register is free.
  assign advance = !q_status.empty && (!out_valid || !out_stall);
  assign pop     = advance && is_last;

  // Step counter and shadow byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      shadow <= '0;
    end else if (advance) begin
      step   <= is_last ? 4'd0 : step + 4'd1;
      shadow <= shadow_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame <= shadow_next;
      last  <= is_last;
    end
  end

endmodule

/* src/lcd_nibble_shift_frame_sequencer.sv */
`timescale 1ns / 1ps
// The first frame of an item passes through the queue, then the output register.
// The output register gives one frame per cycle unless stalled; a command or data
// byte gives 9 frames, init nibble 4, backlight item 1; items follow back to back.
// A queue of QUEUE_DEPTH items lets input keep flowing while the output stalls.
// Reset (synchronous, active high) clears the shadow byte, empties the queue and
// returns the line positions to their defaults.
module lcd_nibble_shift_frame_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [2:0] wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] payload,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame,
  output logic       last
);

  lcdns_pkg::cfg_t      cfg;
  lcdns_pkg::entry_t    push_entry;
  lcdns_pkg::entry_t    head;
  lcdns_pkg::q_status_t q_status;
  logic                 push;
  logic                 pop;

  // Line position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rs <= 3'd1;
      cfg.en <= 3'd3;
      cfg.bl <= 3'd2;
      cfg.d4 <= 3'd4;
      cfg.d5 <= 3'd5;
      cfg.d6 <= 3'd6;
      cfg.d7 <= 3'd7;
    end else if (wr_en) begin
      case (wr_index)
        lcdns_pkg::REG_RS: cfg.rs <= wr_data;
        lcdns_pkg::REG_EN: cfg.en <= wr_data;
        lcdns_pkg::REG_BL: cfg.bl <= wr_data;
        lcdns_pkg::REG_D4: cfg.d4 <= wr_data;
        lcdns_pkg::REG_D5: cfg.d5 <= wr_data;
        lcdns_pkg::REG_D6: cfg.d6 <= wr_data;
        lcdns_pkg::REG_D7: cfg.d7 <= wr_data;
        default: ;
      endcase
    end
  end

  lcdns_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .payload    (payload),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  lcdns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  lcdns_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame     (frame),
    .last      (last)
  );

endmodule

/* src/lcdns_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the LCD nibble frame sequencer, bound to its top level.
// Depends only on the top level's ports.
module lcdns_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] frame,
  input logic       last
);

  // A stalled result item holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame) && $stable(last))
    else $error("stalled item changed");

  // Nothing is offered straight after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The frames of one item come without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside an item's frames");

  // Consecutive frames of one item change at most four lines.
  a_small_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> $countones(frame ^ $past(frame)) <= 4)
    else $error("too many lines changed between frames");

endmodule

bind lcd_nibble_shift_frame_sequencer lcdns_checker u_lcdns_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .frame     (frame),
  .last      (last)
);

/* sim/tb_lcd_nibble_shift_frame_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lcd_nibble_shift_frame_sequencer: a directed table, then
// random items under several line-position settings and idle/stall mixes.
// Depends on lcdns_pkg and the block; every frame is checked against a local predictor.
module tb_lcd_nibble_shift_frame_sequencer;

  // Kind codes the block has no use for; they must produce no frame.
  localparam logic [2:0] KIND_SPARE5 = 3'd5;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 18;
  localparam int NUM_PHASES  = 8;
  localparam int NUM_STEPS   = 22;

  // One expected frame and its end-of-item flag.
  typedef struct packed {
    logic [7:0] bits;
    logic       fin;
  } frame_rec_t;

  // One row of the directed table; typed rows carry the final frame written out by hand.
  typedef struct packed {
    logic [2:0] k;
    logic [7:0] p;
    logic       typed;
    logic [7:0] want;
  } step_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       wr_en    = 1'b0;
  logic [2:0] wr_index = 3'd0;
  logic [2:0] wr_data  = 3'd0;
  logic       in_valid = 1'b0;
  logic [2:0] kind     = 3'd0;
  logic [7:0] payload  = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] frame;
  logic       last;

  // Predictor state: the shadow byte and the current line positions.
  logic [7:0]      shadow = 8'h00;
  lcdns_pkg::cfg_t lines;

  frame_rec_t pending_frames[$];
  frame_rec_t oldest;

  int  idle_pct       = 0;
  int  stall_pct      = 0;
  bit  hold_req       = 1'b0;
  int  mismatches     = 0;
  int  frames_checked = 0;
  int  items_sent     = 0;
  int  settings_used  = 1;

  // Directed items, starting from the reset positions and a clear shadow byte.
  step_t steps [NUM_STEPS] = '{
    '{lcdns_pkg::KIND_BL_OFF, 8'h00, 1'b1, 8'h04},
    '{lcdns_pkg::KIND_BL_ON,  8'hFF, 1'b1, 8'h00},
    '{lcdns_pkg::KIND_CMD,    8'h00, 1'b1, 8'h00},
    '{lcdns_pkg::KIND_DATA,   8'hFF, 1'b1, 8'hF2},
    '{lcdns_pkg::KIND_BL_OFF, 8'h00, 1'b1, 8'hF6},
    '{KIND_SPARE5,            8'hFF, 1'b0, 8'h00},
    '{KIND_SPARE7,            8'h00, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_INIT,   8'hF3, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_INIT,   8'hF0, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_CMD,    8'hA5, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_DATA,   8'h5A, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_CMD,    8'h80, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_DATA,   8'h01, 1'b0, 8'h00},
    '{KIND_SPARE6,            8'h3C, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_CMD,    8'hFF, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_DATA,   8'h00, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_INIT,   8'h0F, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_INIT,   8'h08, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_BL_ON,  8'h00, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_DATA,   8'h7E, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_BL_OFF, 8'hFF, 1'b0, 8'h00},
    '{lcdns_pkg::KIND_BL_OFF, 8'h55, 1'b0, 8'h00}
  };

  lcd_nibble_shift_frame_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .payload   (payload),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame     (frame),
    .last      (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Works out the frames one item produces and queues them; returns how many.
  function automatic int predict_frames(input logic [2:0] k, input logic [7:0] p,
                                        input logic typed, input logic [7:0] want);
    logic [7:0] fr [9];
    logic [3:0] nibs [2];
    int n;
    int nn;
    n  = 0;
    nn = 0;
    case (k)
      lcdns_pkg::KIND_CMD, lcdns_pkg::KIND_DATA: begin
        shadow[lines.rs] = k[0];
        fr[n] = shadow;
        n++;
        nibs[0] = p[7:4];
        nibs[1] = p[3:0];
        nn = 2;
      end
      lcdns_pkg::KIND_INIT: begin
        nibs[0] = p[3:0];
        nn = 1;
      end
      lcdns_pkg::KIND_BL_ON: begin
        shadow[lines.bl] = 1'b0;
        fr[n] = shadow;
        n++;
      end
      lcdns_pkg::KIND_BL_OFF: begin
        shadow[lines.bl] = 1'b1;
        fr[n] = shadow;
        n++;
      end
      default: ;
    endcase
    // Each nibble: data lines D4 to D7 in order, then the enable strobe low, high, low.
    for (int j = 0; j < nn; j++) begin
      shadow[lines.d4] = nibs[j][0];
      shadow[lines.d5] = nibs[j][1];
      shadow[lines.d6] = nibs[j][2];
      shadow[lines.d7] = nibs[j][3];
      fr[n] = shadow;
      n++;
      shadow[lines.en] = 1'b0;
      fr[n] = shadow;
      n++;
      shadow[lines.en] = 1'b1;
      fr[n] = shadow;
      n++;
      shadow[lines.en] = 1'b0;
      fr[n] = shadow;
      n++;
    end
    if (typed && n > 0) fr[n-1] = want;
    for (int i = 0; i < n; i++) begin
      pending_frames.push_back(frame_rec_t'{bits: fr[i], fin: (i == n - 1)});
    end
    return n;
  endfunction

  // Offers one item, with a random gap first, and returns in the step it is accepted.
  task automatic offer_item(input logic [2:0] k, input logic [7:0] p,
                            input logic typed, input logic [7:0] want);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    kind     <= k;
    payload  <= p;
    do @(posedge clk); while (in_stall);
    if (predict_frames(k, p, typed, want) != 0) items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [2:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  // Waits for the block to go quiet, then loads a full set of line positions.
  task automatic apply_positions(input lcdns_pkg::cfg_t c);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    // Let the block sit idle before the positions change.
    repeat (6) @(posedge clk);
    write_reg(lcdns_pkg::REG_RS, c.rs);
    write_reg(lcdns_pkg::REG_EN, c.en);
    write_reg(lcdns_pkg::REG_BL, c.bl);
    write_reg(lcdns_pkg::REG_D4, c.d4);
    write_reg(lcdns_pkg::REG_D5, c.d5);
    write_reg(lcdns_pkg::REG_D6, c.d6);
    write_reg(lcdns_pkg::REG_D7, c.d7);
    wr_en <= 1'b0;
    lines = c;
    settings_used++;
  endtask

  // Output side: random stalls, with a long hold-off whenever one is requested.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Compares every accepted frame with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("frame %02h arrived with nothing expected", frame);
        mismatches++;
      end else begin
        oldest = pending_frames.pop_front();
        frames_checked++;
        if (frame !== oldest.bits) begin
          $error("frame: expected %02h, got %02h", oldest.bits, frame);
          mismatches++;
        end
        if (last !== oldest.fin) begin
          $error("last: expected %0b, got %0b", oldest.fin, last);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    lcdns_pkg::cfg_t c;
    logic [2:0] k;
    int ph;
    int i;
    int r;

    lines = '{rs: 3'd1, en: 3'd3, bl: 3'd2, d4: 3'd4, d5: 3'd5, d6: 3'd6, d7: 3'd7};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset positions.
    for (i = 0; i < NUM_STEPS; i++) offer_item(steps[i].k, steps[i].p, steps[i].typed,
                                               steps[i].want);

    // Random phases, each under its own positions and idle/stall mix.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: c = '{rs: 3'd1, en: 3'd3, bl: 3'd2, d4: 3'd4, d5: 3'd5, d6: 3'd6, d7: 3'd7};
        1: c = '0;
        2: c = '1;
        3: c = '{rs: 3'd4, en: 3'd7, bl: 3'd0, d4: 3'd4, d5: 3'd4, d6: 3'd1, d7: 3'd7};
        5: c = '{rs: 3'd0, en: 3'd1, bl: 3'd2, d4: 3'd7, d5: 3'd6, d6: 3'd5, d7: 3'd4};
        default: c = 21'($urandom);
      endcase
      apply_positions(c);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      // Hold the output off for a long stretch while items keep coming.
      if (ph == 4) hold_req = 1'b1;
      i = 0;
      while (i < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 35) k = lcdns_pkg::KIND_CMD;
        else if (r < 70) k = lcdns_pkg::KIND_DATA;
        else if (r < 82) k = lcdns_pkg::KIND_INIT;
        else if (r < 88) k = lcdns_pkg::KIND_BL_ON;
        else if (r < 94) k = lcdns_pkg::KIND_BL_OFF;
        else begin
          case ($urandom_range(2))
            0: k = KIND_SPARE5;
            1: k = KIND_SPARE6;
            default: k = KIND_SPARE7;
          endcase
        end
        offer_item(k, 8'($urandom_range(255)), 1'b0, 8'h00);
        if (r < 94) i++;
      end
    end

    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Ran %0d items giving %0d frames under %0d line-position settings,",
             items_sent, frames_checked, settings_used);
    $display("including shared and extreme positions, ignored kinds and a long hold-off.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #200000;
    $display("Run timed out with %0d frames still expected.", pending_frames.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
